>>> rtl/cbad_pkg.sv
`default_nettype none

package cbad_pkg;

  // Field widths of the stream items.
  localparam int SAMPLE_W      = 12;
  localparam int SAMPLE_FIELDS = 4;
  localparam int IN_DATA_W     = 48;
  localparam int SUM_W         = 30;
  localparam int OUT_DATA_W    = 32;
  localparam int COUNT_W       = 16;

  // Four 12-bit samples sum to at most 14 bits.
  localparam int DELTA_W = SAMPLE_W + 2;

  // Default block length: sample rate over output rate.
  localparam int SAMPLE_RATE = 10000;
  localparam int OUTPUT_RATE = 3;
  localparam logic [COUNT_W-1:0] BLOCK_RESET = COUNT_W'(SAMPLE_RATE / OUTPUT_RATE);

  localparam int CHANNELS_DEFAULT = 4;

  // Kind of an input item, carried in tuser.
  typedef enum logic {
    CMD_CONVERT = 1'b0,
    CMD_ACK     = 1'b1
  } cmd_t;

  typedef logic signed [SUM_W-1:0] sum_t;

endpackage

`default_nettype wire

>>> rtl/cbad_demod.sv
`default_nettype none

module cbad_demod
  import cbad_pkg::*;
#(
  parameter int CHANNEL_COUNT = CHANNELS_DEFAULT
) (
  input  wire logic [IN_DATA_W-1:0] samples,
  input  wire logic                 add,
  input  wire sum_t                 base,
  output sum_t                      sum
);

  // Only four sample fields exist; larger counts use all of them.
  localparam int USED = (CHANNEL_COUNT < SAMPLE_FIELDS) ? CHANNEL_COUNT : SAMPLE_FIELDS;

  logic signed [DELTA_W-1:0] delta;
  logic signed [SUM_W:0]     wide;

  always_comb begin
    delta = '0;
    for (int i = 0; i < USED; i++) begin
      delta = delta + DELTA_W'($signed(samples[i*SAMPLE_W +: SAMPLE_W]));
    end
  end

  always_comb begin
    if (add) begin
      wide = (SUM_W+1)'(base) + (SUM_W+1)'(delta);
    end else begin
      wide = (SUM_W+1)'(base) - (SUM_W+1)'(delta);
    end
  end

  // Saturate when the two top bits disagree.
  always_comb begin
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sum = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum = wide[SUM_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/chopped_bridge_accumulate_dump.sv
// Synchronous demodulator for a chopped load-cell bridge, accumulate and dump.
// Input stream (s_axis_*): each transfer is either a conversion carrying four
// signed 12-bit channel samples in tdata, or an acknowledge from the consumer,
// chosen by tuser. A conversion toggles the drive phase and counts down the
// block; when the count runs out the running sum closes and one result is
// issued on the output stream (m_axis_*): the sum in tdata and, in tuser,
// whether it was published or dropped because the previous one was still
// unacknowledged. Samples are then added in the high phase and subtracted in
// the low phase, into a saturating 30-bit accumulator.
// Throughput is one item per clock. A result appears in the output register
// in the cycle after the closing conversion is transferred. The output register
// parts the two sides: while it is full and the receiver stalls, s_axis_tready
// is low; when the receiver takes it, a new item is taken in the same cycle.
// Synchronous reset clears the accumulator, phase and acknowledge flag, loads
// the block length and the countdown with 3333 and empties the output.
// cfg_we writes cfg_data into the block length; it applies at the next reload.
`default_nettype none

module chopped_bridge_accumulate_dump
  import cbad_pkg::*;
#(
  parameter int CHANNEL_COUNT = CHANNELS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [COUNT_W-1:0]    cfg_data,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // sample_a [11:0], sample_b [23:12], sample_c [35:24], sample_d [47:36]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command [0]
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // block_sum [29:0], zero fill [31:30]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // published [0]
  output logic                       m_axis_tuser
);

  logic [COUNT_W-1:0] block_length;
  logic [COUNT_W-1:0] conversions_left;
  sum_t               running_sum;
  logic               drive_phase;
  logic               awaiting_ack;

  logic               out_valid;
  sum_t               out_sum;
  logic               out_published;

  logic               in_xfer;
  logic               is_ack;
  logic               is_convert;
  logic [COUNT_W-1:0] left_dec;
  logic               closing;
  sum_t               sum_base;
  sum_t               running_sum_next;

  // The output register is free, or it is being emptied this cycle.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign is_ack        = (cmd_t'(s_axis_tuser) == CMD_ACK);
  assign is_convert    = in_xfer && !is_ack;

  // A block of length zero wraps the countdown and lasts 65536 conversions.
  assign left_dec = conversions_left - COUNT_W'(1);
  assign closing  = (left_dec == '0);
  assign sum_base = closing ? '0 : running_sum;

  // The phase is toggled before the samples are applied.
  cbad_demod #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_demod (
    .samples(s_axis_tdata),
    .add    (!drive_phase),
    .base   (sum_base),
    .sum    (running_sum_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLOCK_RESET;
    end else if (cfg_we) begin
      block_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conversions_left <= BLOCK_RESET;
      running_sum      <= '0;
      drive_phase      <= 1'b0;
      awaiting_ack     <= 1'b0;
    end else if (in_xfer) begin
      if (is_ack) begin
        awaiting_ack <= 1'b0;
      end else begin
        drive_phase      <= !drive_phase;
        running_sum      <= running_sum_next;
        conversions_left <= closing ? block_length : left_dec;
        if (closing) begin
          awaiting_ack <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_convert && closing) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // A dropped sum is still reported, with published low.
  always_ff @(posedge clk) begin
    if (is_convert && closing) begin
      out_sum       <= running_sum;
      out_published <= !awaiting_ack;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-SUM_W){1'b0}}, out_sum};
  assign m_axis_tuser  = out_published;

`ifndef SYNTHESIS
  // A closing conversion always leaves the output owned by the consumer.
  a_close_sets_ack: assert property (@(posedge clk) disable iff (rst)
    (is_convert && closing) |=> awaiting_ack)
    else $error("awaiting_ack not set after a block closed");

  // An acknowledge never causes a result.
  a_ack_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && is_ack) |=> !m_axis_tvalid)
    else $error("result issued after an acknowledge transfer");

  // A published result on offer implies the block is waiting for its ack.
  a_published_pending: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> awaiting_ack)
    else $error("published result without pending acknowledge");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
module testbench;
  import cbad_pkg::*;

  // This limit leaves ample room for a normal run.
  localparam int RUN_LIMIT = 10_000_000;

  localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -(longint'(1) << (SUM_W - 1));

  // One closed averaging block as it should leave the output stream.
  typedef struct {
    sum_t block_sum;
    logic published;
  } closed_block_t;

  // How conversions are filled while running a block to its close.
  typedef enum {
    FILL_RANDOM,
    FILL_POSITIVE,
    FILL_NEGATIVE
  } fill_t;

  // Demodulator predictor and checker. It mirrors the block's state, turns every
  // accepted input transfer into its expected closed block (if any), and compares
  // each output transfer with the oldest sum still due.
  class demod_checker;
    logic [COUNT_W-1:0] block_len;
    logic [COUNT_W-1:0] left;
    sum_t acc;
    logic drive_high;
    logic ack_pending;
    closed_block_t sums_due[$];
    int closed;
    int mismatches;

    function new();
      block_len = BLOCK_RESET;
      left = BLOCK_RESET;
      acc = '0;
      drive_high = 1'b0;
      ack_pending = 1'b0;
      closed = 0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return sums_due.size();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function void note_transfer(cmd_t cmd, logic [IN_DATA_W-1:0] data);
      logic signed [SAMPLE_W-1:0] smp;
      int delta;
      longint nxt;
      if (cmd == CMD_ACK) begin
        ack_pending = 1'b0;
        return;
      end
      drive_high = ~drive_high;
      left = left - 1'b1;
      // The closing conversion publishes the old sum; its own samples open
      // the next block.
      if (left == '0) begin
        sums_due.push_back('{acc, ~ack_pending});
        ack_pending = 1'b1;
        acc = '0;
        left = block_len;
        closed++;
      end
      delta = 0;
      for (int i = 0; i < CHANNELS_DEFAULT && i < SAMPLE_FIELDS; i++) begin
        smp = data[i*SAMPLE_W +: SAMPLE_W];
        delta += smp;
      end
      nxt = drive_high ? longint'(acc) + delta : longint'(acc) - delta;
      if (nxt > SUM_HI) nxt = SUM_HI;
      if (nxt < SUM_LO) nxt = SUM_LO;
      acc = sum_t'(nxt);
    endfunction

    task check_block_sum(logic [OUT_DATA_W-1:0] data, logic published);
      closed_block_t exp;
      if (sums_due.size() == 0) begin
        report_mismatch($sformatf("block sum %0d arrived with none due",
                                  $signed(data[SUM_W-1:0])));
        return;
      end
      exp = sums_due.pop_front();
      if (data[SUM_W-1:0] !== exp.block_sum)
        report_mismatch($sformatf("block_sum %0d, expected %0d",
                                  $signed(data[SUM_W-1:0]), exp.block_sum));
      if (data[OUT_DATA_W-1:SUM_W] !== '0)
        report_mismatch($sformatf("tdata fill bits %b are not zero",
                                  data[OUT_DATA_W-1:SUM_W]));
      if (published !== exp.published)
        report_mismatch($sformatf("published %b, expected %b", published,
                                  exp.published));
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  demod_checker sb = new();

  // Idle percentages for the sender gaps and the receiver stalls; zero turns
  // idling off on that side.
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  chopped_bridge_accumulate_dump i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("FAILURE");
    $finish;
  end

  // Receiver side. Stalls come in bursts. Output transfers are checked at the
  // edge that completes them, so the values seen are the ones the block held
  // before the edge.
  always @(posedge clk) begin
    if (stall_pct == 0) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
      sb.check_block_sum(m_axis_tdata, m_axis_tuser);
  end

  // Converter values lean toward the extremes and the sign boundary.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 12'h7FF;
      1: return 12'h800;
      2: return 12'h000;
      3: return 12'hFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offers one item and holds it until the block takes it. The predictor is
  // updated at the accepting edge; a result can only show up after that edge.
  task automatic send_transfer(cmd_t cmd, logic [IN_DATA_W-1:0] data);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= cmd;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_transfer(cmd, data);
  endtask

  // Mostly conversions; about one item in five is a consumer acknowledge.
  task automatic send_random_item();
    cmd_t cmd;
    cmd = ($urandom_range(0, 4) == 0) ? CMD_ACK : CMD_CONVERT;
    send_transfer(cmd, {pick_sample(), pick_sample(), pick_sample(), pick_sample()});
  endtask

  // The register may only change while nothing is in flight.
  task automatic write_block_length(logic [COUNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.block_len = value;
  endtask

  // The sender holds off until every due sum has been delivered, then waits
  // for the last conversion to settle inside the block.
  task automatic wait_sums_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sends conversions until one more block closes. The steered fills pick the
  // sign of every sample from the phase the conversion is about to enter, so
  // the block sum grows as fast as the samples allow.
  task automatic run_to_block_close(fill_t fill);
    int target;
    logic next_high;
    logic [IN_DATA_W-1:0] data;
    target = sb.closed + 1;
    while (sb.closed < target) begin
      next_high = ~sb.drive_high;
      case (fill)
        FILL_POSITIVE: data = next_high ? {4{12'h7FF}} : {4{12'h800}};
        FILL_NEGATIVE: data = next_high ? {4{12'h800}} : {4{12'h7FF}};
        default: data = {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
      endcase
      send_transfer(CMD_CONVERT, data);
    end
  endtask

  initial begin
    int lens[6];
    int gaps[6];
    int stalls[6];
    lens = '{1, 2, 3, 0, 5, 2};
    lens[3] = $urandom_range(4, 40);
    gaps = '{20, 0, 40, 10, 60, 15};
    stalls = '{20, 40, 0, 60, 10, 30};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Shortest block length first. The countdown still runs from its reset
    // value, so the first block closes only after 3333 conversions.
    write_block_length(16'd1);

    // Directed items: an acknowledge with nothing pending, all-max and all-min
    // channels, zero and minus one, mixed signs and alternating bit patterns.
    send_transfer(CMD_ACK, '0);
    send_transfer(CMD_CONVERT, {4{12'h7FF}});
    send_transfer(CMD_CONVERT, {4{12'h7FF}});
    send_transfer(CMD_CONVERT, {4{12'h800}});
    send_transfer(CMD_CONVERT, {4{12'h800}});
    send_transfer(CMD_CONVERT, '0);
    send_transfer(CMD_CONVERT, {4{12'hFFF}});
    send_transfer(CMD_CONVERT, {12'hFFF, 12'h000, 12'h800, 12'h7FF});
    send_transfer(CMD_CONVERT, {12'h7FF, 12'h800, 12'h000, 12'hFFF});
    send_transfer(CMD_CONVERT, {4{12'hAAA}});
    send_transfer(CMD_CONVERT, {4{12'h555}});
    send_transfer(CMD_ACK, {4{12'hFFF}});
    send_transfer(CMD_CONVERT, {12'h001, 12'h002, 12'h004, 12'h008});
    send_transfer(CMD_ACK, {4{12'h555}});
    send_transfer(CMD_CONVERT, {12'h800, 12'h7FF, 12'h800, 12'h7FF});

    // Fill the long first block under moderate idling on both sides.
    gap_pct = 20;
    stall_pct = 20;
    run_to_block_close(FILL_RANDOM);

    // With length one every conversion closes a block, and back-to-back
    // conversions without acknowledges exercise the dropped-sum path.
    for (int p = 0; p < 6; p++) begin
      wait_sums_drained();
      write_block_length(COUNT_W'(lens[p]));
      gap_pct = gaps[p];
      stall_pct = stalls[p];
      repeat (190) send_random_item();
    end

    // Last part, no idling. Blocks of forty conversions are driven toward the
    // positive and then the negative limit. The close of the negative block
    // loads a zero length, so the countdown wraps and no further block closes
    // during the closing random items.
    wait_sums_drained();
    gap_pct = 0;
    stall_pct = 0;
    write_block_length(16'd40);
    send_transfer(CMD_ACK, '0);
    // This first close ends the short block still running from before.
    run_to_block_close(FILL_POSITIVE);
    run_to_block_close(FILL_POSITIVE);
    send_transfer(CMD_ACK, '0);
    wait_sums_drained();
    write_block_length('0);
    run_to_block_close(FILL_NEGATIVE);
    repeat (20) send_random_item();

    wait_sums_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
